>>> rtl/mws_pkg.sv
`timescale 1ns / 1ps

package mws_pkg;

    localparam int MAX_WINDOW    = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int SUM_BITS      = 42;
    localparam int STORE_BITS    = 32;
    localparam int IDX_BITS      = $clog2(MAX_WINDOW);
    localparam int LEN_BITS      = IDX_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int OUT_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AVERAGE_MODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SQUARE_INPUT = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] WINDOW_SIZE_RESET = 11'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    // zero acts as one, oversized clamps to the store depth
    function automatic logic [LEN_BITS-1:0] window_length(
        input logic [CFG_DATA_BITS-1:0] size
    );
        logic [LEN_BITS-1:0] len;
        if (size == '0) begin
            len = LEN_BITS'(1);
        end else if (size > CFG_DATA_BITS'(MAX_WINDOW)) begin
            len = LEN_BITS'(MAX_WINDOW);
        end else begin
            len = LEN_BITS'(size);
        end
        return len;
    endfunction

endpackage

>>> rtl/moving_window_sum.sv
`timescale 1ns / 1ps

// moving window sum / mean of signed 16-bit samples
//
// input channel s_axis: one sample per word in tdata[15:0]
// output channel m_axis: one result word per input word, tdata[41:0] holds
//   the window sum (or mean) as 42-bit two's complement, upper bits zero
// config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 window_size, 1 average_mode, 2 square_input); write only while idle
//
// sequence: a word passes the value step (S_MUL) and the sum step (S_SUM), in mean
//   mode also the bit-serial divider (S_DIV), then waits in S_OUT to load the output
// throughput: one word at a time; s_axis_tready is high only while idle, so the
//   next word is taken only once the last result has moved into the output register
// the ring of past values lives in a 1024 x 32 one-port-read memory; a fill
//   count marks which entries were written since reset, the rest read as zero
// reset: sums, write index and fill count clear, registers take 64 / 0 / 0,
//   output goes invalid; no clearing pass is needed
// receiver stall: the result waits in the output register while the next
//   word is already taken and worked on; it stalls only when that one is done

module moving_window_sum (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write port
    input  logic                                     i_cfg_we,
    input  logic [mws_pkg::CFG_IDX_BITS-1:0]         i_cfg_idx,
    input  logic [mws_pkg::CFG_DATA_BITS-1:0]        i_cfg_data,
    // sample input
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [mws_pkg::IN_TDATA_BITS-1:0]        s_axis_tdata,  // [15:0] sample
    // result output
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [mws_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata   // [41:0] window_value
);

    localparam int SB = mws_pkg::SUM_BITS;
    localparam int XB = mws_pkg::STORE_BITS;
    localparam int IB = mws_pkg::IDX_BITS;
    localparam int LB = mws_pkg::LEN_BITS;
    localparam int NB = mws_pkg::SAMPLE_BITS;

    // configuration
    logic [mws_pkg::CFG_DATA_BITS-1:0] r_window_size;
    logic                              r_average;
    logic                              r_square;
    logic [LB-1:0]                     len;

    // control
    mws_pkg::t_state r_state, n_state;
    logic            in_accept;
    logic            out_load;

    // window state
    logic [IB-1:0]           r_idx;
    logic [LB-1:0]           r_fill;
    logic signed [SB-1:0]    r_main;
    logic signed [SB-1:0]    r_safe;

    // datapath
    logic signed [NB-1:0]    r_sample;
    logic signed [XB-1:0]    r_x;
    logic signed [SB-1:0]    r_res;
    logic                    r_out_valid;
    logic signed [SB-1:0]    r_out_data;

    logic [NB:0]             abs_sample;
    logic signed [XB-1:0]    rd_data;
    logic signed [XB-1:0]    old_val;
    logic signed [SB-1:0]    x_ext;
    logic signed [SB-1:0]    new_main;
    logic signed [SB-1:0]    new_safe;
    logic [LB-1:0]           idx_inc;
    logic                    wrap;
    logic                    div_start;
    logic                    div_done;
    logic signed [SB-1:0]    div_quo;

    assign len = mws_pkg::window_length(r_window_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= mws_pkg::WINDOW_SIZE_RESET;
            r_average     <= 1'b0;
            r_square      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mws_pkg::CFG_WINDOW_SIZE:  r_window_size <= i_cfg_data;
                mws_pkg::CFG_AVERAGE_MODE: r_average     <= i_cfg_data[0];
                mws_pkg::CFG_SQUARE_INPUT: r_square      <= i_cfg_data[0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == mws_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    // result moves into the output register when it is empty or being drained
    assign out_load      = (r_state == mws_pkg::S_OUT) && (!r_out_valid || m_axis_tready);
    assign div_start     = (r_state == mws_pkg::S_SUM) && r_average;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mws_pkg::S_IDLE: if (in_accept) n_state = mws_pkg::S_MUL;
            mws_pkg::S_MUL:  n_state = mws_pkg::S_SUM;
            mws_pkg::S_SUM:  n_state = r_average ? mws_pkg::S_DIV : mws_pkg::S_OUT;
            mws_pkg::S_DIV:  if (div_done) n_state = mws_pkg::S_OUT;
            mws_pkg::S_OUT:  if (out_load) n_state = mws_pkg::S_IDLE;
            default:         n_state = mws_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // value stage: optional square, registered
    // ------------------------------------------------------------------
    assign abs_sample = r_sample[NB-1] ? (NB+1)'(-$signed({r_sample[NB-1], r_sample}))
                                       : (NB+1)'({r_sample[NB-1], r_sample});

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= s_axis_tdata[NB-1:0];
        end
        if (r_state == mws_pkg::S_MUL) begin
            r_x <= r_square ? XB'(abs_sample * abs_sample) : XB'(r_sample);
        end
    end

    // ------------------------------------------------------------------
    // ring store: read oldest on accept, write new value in the sum step
    // ------------------------------------------------------------------
    mws_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == mws_pkg::S_SUM),
        .i_wr_addr (r_idx),
        .i_wr_data (r_x)
    );

    // entries at or past the fill count were never written and read as zero
    assign old_val  = ({1'b0, r_idx} < r_fill) ? rd_data : '0;
    assign x_ext    = SB'(r_x);
    assign new_main = r_main + x_ext - SB'(old_val);
    assign new_safe = r_safe + x_ext;
    assign idx_inc  = {1'b0, r_idx} + 1'b1;
    assign wrap     = (idx_inc >= len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_fill <= '0;
            r_main <= '0;
            r_safe <= '0;
        end else if (r_state == mws_pkg::S_SUM) begin
            if (idx_inc > r_fill) begin
                r_fill <= idx_inc;
            end
            if (wrap) begin
                // resync main sum from the drift-free safe sum
                r_idx  <= '0;
                r_main <= new_safe;
                r_safe <= '0;
            end else begin
                r_idx  <= idx_inc[IB-1:0];
                r_main <= new_main;
                r_safe <= new_safe;
            end
        end
    end

    // ------------------------------------------------------------------
    // mean: serial divide by the window length
    // ------------------------------------------------------------------
    mws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (new_main),
        .i_divisor  (len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == mws_pkg::S_SUM) begin
            r_res <= new_main;
        end else if ((r_state == mws_pkg::S_DIV) && div_done) begin
            r_res <= div_quo;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = mws_pkg::OUT_TDATA_BITS'(unsigned'(r_out_data));

endmodule

>>> rtl/mws_store.sv
`timescale 1ns / 1ps

module mws_store (
    input  logic                                  i_clk,
    input  logic                                  i_rd_en,
    input  logic [mws_pkg::IDX_BITS-1:0]          i_rd_addr,
    output logic signed [mws_pkg::STORE_BITS-1:0] o_rd_data,
    input  logic                                  i_wr_en,
    input  logic [mws_pkg::IDX_BITS-1:0]          i_wr_addr,
    input  logic signed [mws_pkg::STORE_BITS-1:0] i_wr_data
);

    logic signed [mws_pkg::STORE_BITS-1:0] r_mem [mws_pkg::MAX_WINDOW];
    logic signed [mws_pkg::STORE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/mws_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, truncates toward zero
module mws_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mws_pkg::SUM_BITS-1:0] i_dividend,
    input  logic [mws_pkg::LEN_BITS-1:0]        i_divisor,
    output logic                                o_done,
    output logic signed [mws_pkg::SUM_BITS-1:0] o_quotient
);

    localparam int RB = mws_pkg::LEN_BITS - 1;

    logic                               r_busy;
    logic                               r_done;
    logic [mws_pkg::DIV_CNT_BITS-1:0]   r_cnt;
    logic                               r_neg;
    logic [mws_pkg::SUM_BITS-1:0]       r_quo;
    logic [RB-1:0]                      r_rem;
    logic [mws_pkg::LEN_BITS-1:0]       r_divisor;

    logic [mws_pkg::LEN_BITS-1:0]       trial;
    logic                               fits;

    assign trial = {r_rem, r_quo[mws_pkg::SUM_BITS-1]};
    assign fits  = (trial >= r_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == mws_pkg::DIV_CNT_BITS'(mws_pkg::SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg     <= i_dividend[mws_pkg::SUM_BITS-1];
            r_quo     <= i_dividend[mws_pkg::SUM_BITS-1] ? -i_dividend : i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? RB'(trial - r_divisor) : trial[RB-1:0];
            r_quo <= {r_quo[mws_pkg::SUM_BITS-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

>>> rtl/mws_checker.sv
`timescale 1ns / 1ps

module mws_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [mws_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // one word in flight: ready drops right after a word is taken
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in flight");

    // after reset the block is idle with no pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

endmodule

bind moving_window_sum mws_checker u_mws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
